FILE: rtl/assert_macros.svh
// assertion helpers used by the timer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define BZCT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define BZCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bzct_pkg.sv
// ---------------------------------------------------------------------------
// bzct_pkg
// Types, codes and section decode tables for the back-emf zero-crossing timer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bzct_pkg;

	localparam int unsigned SECTION_COUNT = 6;

	// request codes
	localparam logic REQ_EDGE        = 1'b0;
	localparam logic REQ_SECTION_END = 1'b1;

	// phase codes
	localparam logic [1:0] PHASE_A = 2'd0;
	localparam logic [1:0] PHASE_B = 2'd1;
	localparam logic [1:0] PHASE_C = 2'd2;

	// classification codes
	typedef enum logic [1:0] {
		OUTCOME_NONE     = 2'd0,
		OUTCOME_VALID    = 2'd1,
		OUTCOME_TOO_EARLY = 2'd2,
		OUTCOME_TOO_LATE = 2'd3
	} outcome_t;

	typedef struct packed {
		logic        req_type;
		logic [1:0]  phase;
		logic        edge_req;
		logic [2:0]  section;
		logic [2:0]  next_section;
		logic [31:0] timestamp;
		logic [2:0]  comparator_levels;
		logic [31:0] sixty_deg_time;
	} in_item_t;

	typedef struct packed {
		outcome_t    outcome;
		logic [31:0] position_time;
		logic [2:0]  phase_enable_mask;
	} out_item_t;

	// measurement state carried between beats
	typedef struct packed {
		logic [31:0] crossing_time;
		logic        crossing_captured;
		logic [2:0]  enabled_phases;
	} meas_state_t;

	// floating phase of a commutation section
	function automatic logic [1:0] float_phase(input logic [2:0] sec);
		logic [1:0] ph;
		unique case (sec)
			3'd0: ph = PHASE_B;
			3'd1: ph = PHASE_A;
			3'd2: ph = PHASE_C;
			3'd3: ph = PHASE_B;
			3'd4: ph = PHASE_A;
			3'd5: ph = PHASE_C;
			default: ph = PHASE_A;
		endcase
		return ph;
	endfunction

	// expected comparator level after the crossing, also the edge direction
	function automatic logic want_level(input logic [2:0] sec);
		return ~sec[0];
	endfunction

	// one-hot comparator mask of a phase, none for the unused code
	function automatic logic [2:0] phase_mask(input logic [1:0] ph);
		logic [2:0] m;
		unique case (ph)
			PHASE_A: m = 3'b001;
			PHASE_B: m = 3'b010;
			PHASE_C: m = 3'b100;
			default: m = 3'b000;
		endcase
		return m;
	endfunction

endpackage

FILE: rtl/bzct_qualify.sv
// ---------------------------------------------------------------------------
// bzct_qualify
// Edge qualification, section-end classification and next measurement state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bzct_qualify (
	input  bzct_pkg::in_item_t    item,
	input  logic                  measure_enable,
	input  bzct_pkg::meas_state_t state_cur,
	output bzct_pkg::meas_state_t state_nxt,
	output logic                  has_result,
	output bzct_pkg::out_item_t   result
);
	import bzct_pkg::*;

	logic        sec_ok;
	logic        nsec_ok;
	logic [1:0]  fp;
	logic        want;
	logic        edge_ok;
	logic        level;
	logic [31:0] elapsed;
	logic [2:0]  next_mask;

	// section decode
	assign sec_ok  = (item.section < 3'(SECTION_COUNT));
	assign nsec_ok = (item.next_section < 3'(SECTION_COUNT));
	assign fp      = float_phase(item.section);
	assign want    = want_level(item.section);

	// edge beat must hit the enabled floating phase in the expected direction
	assign edge_ok = sec_ok
		&& (|(state_cur.enabled_phases & phase_mask(item.phase)))
		&& (fp == item.phase)
		&& (want == item.edge_req);

	// floating comparator level and time since the captured crossing
	assign level     = |(item.comparator_levels & phase_mask(fp));
	assign elapsed   = item.timestamp - state_cur.crossing_time;
	assign next_mask = nsec_ok ? phase_mask(float_phase(item.next_section)) : 3'b000;

	assign has_result = measure_enable && (item.req_type == REQ_SECTION_END);

	// state update and result
	always_comb begin
		state_nxt                = state_cur;
		result.outcome           = OUTCOME_NONE;
		result.position_time     = '0;
		result.phase_enable_mask = next_mask;
		if (measure_enable) begin
			if (item.req_type == REQ_EDGE) begin
				if (edge_ok) begin
					state_nxt.crossing_time     = item.timestamp;
					state_nxt.crossing_captured = 1'b1;
				end
			end else begin
				if (sec_ok) begin
					if (level != want) begin
						result.outcome = OUTCOME_TOO_LATE;
					end else if (!state_cur.crossing_captured) begin
						result.outcome = OUTCOME_TOO_EARLY;
					end else begin
						result.outcome       = OUTCOME_VALID;
						result.position_time = item.sixty_deg_time - elapsed;
					end
				end
				state_nxt.crossing_time     = '0;
				state_nxt.crossing_captured = 1'b0;
				state_nxt.enabled_phases    = next_mask;
			end
		end
	end

endmodule

FILE: rtl/bemf_zero_crossing_timer_core.sv
// Back-EMF zero-crossing timer: takes one beat per clock when the output side
// keeps up. A beat lands in an input register, is classified there against the
// stored crossing capture, and a section-end beat places its result in the
// output register at the first clock edge that finds that register free. While
// a result waits in the output register, edge beats and a further beat into the
// input register are still taken; the input stalls only when a section-end beat
// in the input register finds the output register full and stalled. Measurement
// starts off after reset; enable it through the configuration write while no
// beats are in flight.
// ---------------------------------------------------------------------------
// bemf_zero_crossing_timer_core
// Sensorless bldc back-emf zero-crossing qualifier over six sections.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bemf_zero_crossing_timer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bzct_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output bzct_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	import bzct_pkg::*;

	logic        valid_s1;
	in_item_t    item_s1;
	logic        measure_enable_q;
	meas_state_t state_q;
	meas_state_t state_nxt;
	logic        has_result;
	out_item_t   result;
	logic        out_valid_q;
	out_item_t   out_q;
	logic        out_free;
	logic        adv_s1;
	logic        fire_s1;

	// stage 1 moves on unless its result has nowhere to go
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = !valid_s1 || !has_result || out_free;
	assign fire_s1  = valid_s1 && adv_s1;
	assign in_stall = !adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// classification logic
	bzct_qualify u_qualify (
		.item           (item_s1),
		.measure_enable (measure_enable_q),
		.state_cur      (state_q),
		.state_nxt      (state_nxt),
		.has_result     (has_result),
		.result         (result)
	);

	// measurement state and enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measure_enable_q <= 1'b0;
			state_q          <= '0;
		end else if (cfg_we) begin
			measure_enable_q <= cfg_wdata;
			if (!cfg_wdata) begin
				state_q.enabled_phases <= '0;
			end
		end else if (fire_s1) begin
			state_q <= state_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire_s1 && has_result) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	`BZCT_ASSERT(a_enables_onehot0, clk, arst_n, $onehot0(state_q.enabled_phases), "phase enables not one-hot")
	`BZCT_ASSERT(a_off_no_enables, clk, arst_n, measure_enable_q || (state_q.enabled_phases == 3'b000), "phase enabled while measurement off")
	`BZCT_ASSERT(a_pos_only_valid, clk, arst_n, !out_valid_q || (out_q.outcome == OUTCOME_VALID) || (out_q.position_time == 32'd0), "position time set without valid outcome")
	`BZCT_ASSERT_NEXT(a_result_lands, clk, arst_n, fire_s1 && has_result, out_valid_q && (out_q.phase_enable_mask == $past(result.phase_enable_mask)), "section-end result lost")

endmodule

FILE: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the back-emf zero-crossing timer core. A queue-fed
// driver sends edge and section-end beats with random gaps, a monitor applies
// random output stalls, and a built-in tracker of the crossing capture and
// phase enables predicts every section-end report for in-order checking.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import bzct_pkg::*;

	// unused phase code and synchronising sections
	localparam logic [1:0] PHASE_NONE       = 2'd3;
	localparam logic [2:0] SYNC_SECTION     = 3'd6;
	localparam logic [2:0] SYNC_SECTION_ALT = 3'd7;
	localparam logic       EDGE_FALL        = 1'b0;
	localparam logic       EDGE_RISE        = 1'b1;

	// floating comparator per section 0..5, two bits each, section 0 lowest
	localparam logic [11:0] FLOAT_MAP = {PHASE_C, PHASE_A, PHASE_B, PHASE_C, PHASE_A, PHASE_B};
	// direction of the crossing per section, 1 rising
	localparam logic [5:0] RISING_MAP = 6'b010101;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_we = 1'b0;
	logic      cfg_wdata = 1'b0;

	bemf_zero_crossing_timer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// tracked copy of the capture, enables and measurement switch
	logic [31:0] crossing_time = '0;
	logic        crossing_captured = 1'b0;
	logic [2:0]  enabled_phases = '0;
	logic        measure_on = 1'b0;

	in_item_t  pending_beats[$];
	out_item_t due_reports[$];
	int        mismatch_count = 0;
	int        pushed = 0;
	logic [31:0] rotor_clock = '0;

	int send_gap = 0;
	int send_calm = 0;
	int stall_left = 0;
	int stall_calm = 0;

	function automatic logic [1:0] float_of(input logic [2:0] sec);
		return FLOAT_MAP[2 * sec +: 2];
	endfunction

	function automatic logic rising_in(input logic [2:0] sec);
		return RISING_MAP[sec];
	endfunction

	// gap length: mostly none or short, a few long, now and then a calm stretch
	task automatic idle_span(inout int calm, output int span);
		int roll;
		span = 0;
		if (calm > 0) begin
			calm--;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				calm = $urandom_range(20, 80);
			else if (roll < 55)
				span = 0;
			else if (roll < 92)
				span = $urandom_range(1, 3);
			else
				span = $urandom_range(8, 40);
		end
	endtask

	// update tracked state for one accepted beat, queue the report it causes
	task automatic qualify_crossing(input in_item_t b);
		out_item_t  r;
		logic [1:0] fp;
		if (!measure_on)
			return;
		if (b.req_type == REQ_EDGE) begin
			if (b.phase != PHASE_NONE && b.section < SECTION_COUNT) begin
				if (enabled_phases[b.phase] && float_of(b.section) == b.phase &&
						rising_in(b.section) == b.edge_req) begin
					crossing_time = b.timestamp;
					crossing_captured = 1'b1;
				end
			end
			return;
		end
		r.outcome = OUTCOME_NONE;
		r.position_time = '0;
		if (b.section < SECTION_COUNT) begin
			fp = float_of(b.section);
			if (b.comparator_levels[fp] != rising_in(b.section))
				r.outcome = OUTCOME_TOO_LATE;
			else if (!crossing_captured)
				r.outcome = OUTCOME_TOO_EARLY;
			else begin
				r.outcome = OUTCOME_VALID;
				r.position_time = b.sixty_deg_time - (b.timestamp - crossing_time);
			end
		end
		crossing_time = '0;
		crossing_captured = 1'b0;
		if (b.next_section < SECTION_COUNT)
			enabled_phases = 3'b001 << float_of(b.next_section);
		else
			enabled_phases = '0;
		r.phase_enable_mask = enabled_phases;
		due_reports.push_back(r);
	endtask

	// driver: take the accepted beat, then load the next one or idle
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			qualify_crossing(in_data);
		if (!in_valid || !in_stall) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				in_data <= pending_beats.pop_front();
				in_valid <= 1'b1;
				idle_span(send_calm, send_gap);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check each report against the oldest expectation, vary stall
	always @(posedge clk) begin
		out_item_t want;
		int        span;
		if (out_valid && !out_stall) begin
			if (due_reports.size() == 0) begin
				$error("unexpected report: outcome %0d position_time %0h mask %b",
					out_data.outcome, out_data.position_time, out_data.phase_enable_mask);
				mismatch_count++;
			end else begin
				want = due_reports.pop_front();
				if (out_data.outcome !== want.outcome) begin
					$error("outcome: expected %0d, actual %0d", want.outcome, out_data.outcome);
					mismatch_count++;
				end
				if (out_data.position_time !== want.position_time) begin
					$error("position_time: expected %0h, actual %0h",
						want.position_time, out_data.position_time);
					mismatch_count++;
				end
				if (out_data.phase_enable_mask !== want.phase_enable_mask) begin
					$error("phase_enable_mask: expected %b, actual %b",
						want.phase_enable_mask, out_data.phase_enable_mask);
					mismatch_count++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			idle_span(stall_calm, span);
			out_stall <= (span > 0);
			stall_left = (span > 0) ? span - 1 : 0;
		end
	end

	function automatic in_item_t make_beat(input logic req, input logic [1:0] ph,
			input logic dir, input logic [2:0] sec, input logic [2:0] nsec,
			input logic [31:0] ts, input logic [2:0] lv, input logic [31:0] sixty);
		in_item_t b;
		b.req_type = req;
		b.phase = ph;
		b.edge_req = dir;
		b.section = sec;
		b.next_section = nsec;
		b.timestamp = ts;
		b.comparator_levels = lv;
		b.sixty_deg_time = sixty;
		return b;
	endfunction

	task automatic queue_beat(input in_item_t b);
		pending_beats.push_back(b);
		pushed++;
	endtask

	// fully random beat, phase code 3 and sync sections included
	task automatic queue_noise();
		queue_beat(make_beat(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
			1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
			$urandom, 3'($urandom_range(0, 7)), $urandom));
	endtask

	// a run of commutation sections starting from a synchronising section end
	task automatic queue_rotation(input int sections);
		logic [2:0]  sec;
		logic [2:0]  nxt;
		logic [2:0]  ending;
		logic [2:0]  levels;
		logic [31:0] sixty;
		int          edges;
		sec = 3'($urandom_range(0, 5));
		if ($urandom_range(0, 4) == 0)
			rotor_clock = 32'hFFFF_FFFF - $urandom_range(0, 20000);
		rotor_clock += $urandom_range(1, 1000);
		queue_beat(make_beat(REQ_SECTION_END, 2'($urandom_range(0, 3)),
			1'($urandom_range(0, 1)), 3'($urandom_range(SYNC_SECTION, SYNC_SECTION_ALT)), sec,
			rotor_clock, 3'($urandom_range(0, 7)), $urandom));
		for (int i = 0; i < sections; i++) begin
			sixty = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(50, 5000);
			edges = $urandom_range(0, 3);
			for (int j = 0; j < edges; j++) begin
				rotor_clock += $urandom_range(1, 2000);
				if ($urandom_range(0, 9) < 7)
					queue_beat(make_beat(REQ_EDGE, float_of(sec), rising_in(sec), sec,
						3'($urandom_range(0, 7)), rotor_clock, 3'($urandom_range(0, 7)),
						sixty));
				else
					queue_beat(make_beat(REQ_EDGE, 2'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)),
						($urandom_range(0, 1) != 0) ? sec : 3'($urandom_range(0, 7)),
						3'($urandom_range(0, 7)), rotor_clock, 3'($urandom_range(0, 7)),
						sixty));
			end
			rotor_clock += $urandom_range(1, 3000);
			levels = 3'($urandom_range(0, 7));
			if ($urandom_range(0, 99) < 85)
				levels[float_of(sec)] = rising_in(sec);
			nxt = ($urandom_range(0, 9) != 0) ? 3'((sec + 1) % SECTION_COUNT)
				: 3'($urandom_range(0, 7));
			ending = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : sec;
			queue_beat(make_beat(REQ_SECTION_END, 2'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)), ending, nxt, rotor_clock, levels, sixty));
			sec = (nxt < SECTION_COUNT) ? nxt : 3'($urandom_range(0, 5));
		end
	endtask

	// wait until all beats are taken and all reports are in, then let the pipe drain
	task automatic settle();
		do @(negedge clk);
		while (pending_beats.size() > 0 || in_valid || due_reports.size() > 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_measure(input logic value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		measure_on = value;
		if (!value)
			enabled_phases = '0;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// stimulus
	initial begin
		logic [6:0] plan;
		int         quota;
		int         start;
		plan = 7'b1110011;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// measurement off after reset: nothing reported
		queue_beat(make_beat(REQ_EDGE, PHASE_B, EDGE_RISE, 3'd0, 3'd1, 32'd50, 3'b010, 32'd10));
		queue_beat(make_beat(REQ_SECTION_END, PHASE_A, EDGE_FALL, 3'd0, 3'd1, 32'd60, 3'b010,
			32'd10));
		settle();
		set_measure(1'b1);

		// sync end arms phase b, then filtering of edges in section 0
		queue_beat(make_beat(REQ_SECTION_END, PHASE_A, EDGE_FALL, SYNC_SECTION, 3'd0, 32'd0,
			3'b000, 32'd0));
		queue_beat(make_beat(REQ_EDGE, PHASE_B, EDGE_RISE, 3'd0, 3'd0, 32'd100, 3'b010, 32'd0));
		queue_beat(make_beat(REQ_EDGE, PHASE_A, EDGE_RISE, 3'd0, 3'd0, 32'd150, 3'b011, 32'd0));
		queue_beat(make_beat(REQ_EDGE, PHASE_NONE, EDGE_RISE, 3'd0, 3'd0, 32'd160, 3'b111, 32'd0));
		queue_beat(make_beat(REQ_EDGE, PHASE_B, EDGE_FALL, 3'd0, 3'd0, 32'd170, 3'b000, 32'd0));
		// last accepted edge wins, elapsed time wraps
		queue_beat(make_beat(REQ_EDGE, PHASE_B, EDGE_RISE, 3'd0, 3'd7, 32'hFFFF_FFF0, 3'b010,
			32'hFFFF_FFFF));
		queue_beat(make_beat(REQ_SECTION_END, PHASE_C, EDGE_RISE, 3'd0, 3'd1, 32'h0000_0010,
			3'b010, 32'hFFFF_FFFF));
		// captured but wrong level: too late first
		queue_beat(make_beat(REQ_EDGE, PHASE_A, EDGE_FALL, 3'd1, 3'd2, 32'd0, 3'b000, 32'd9));
		queue_beat(make_beat(REQ_SECTION_END, PHASE_A, EDGE_FALL, 3'd1, 3'd2, 32'd20, 3'b001,
			32'd9));
		// no capture: too early
		queue_beat(make_beat(REQ_SECTION_END, PHASE_A, EDGE_FALL, 3'd2, 3'd4, 32'd30, 3'b100,
			32'd9));
		// edges during synchronising sections are dropped, sync end clears capture
		queue_beat(make_beat(REQ_EDGE, PHASE_A, EDGE_RISE, SYNC_SECTION, 3'd4, 32'd40, 3'b001,
			32'd9));
		queue_beat(make_beat(REQ_EDGE, PHASE_A, EDGE_RISE, SYNC_SECTION_ALT, 3'd4, 32'd41,
			3'b001, 32'd9));
		queue_beat(make_beat(REQ_EDGE, PHASE_A, EDGE_RISE, 3'd4, 3'd5, 32'hFFFF_FFFF, 3'b001,
			32'd9));
		queue_beat(make_beat(REQ_SECTION_END, PHASE_B, EDGE_RISE, SYNC_SECTION_ALT, 3'd3, 32'd42,
			3'b111, 32'hFFFF_FFFF));
		// zero elapsed, zero sixty-degree time; next section none
		queue_beat(make_beat(REQ_EDGE, PHASE_B, EDGE_FALL, 3'd3, 3'd4, 32'd5, 3'b000, 32'd0));
		queue_beat(make_beat(REQ_SECTION_END, PHASE_B, EDGE_FALL, 3'd3, SYNC_SECTION, 32'd5,
			3'b000, 32'd0));
		queue_beat(make_beat(REQ_SECTION_END, PHASE_C, EDGE_FALL, 3'd5, 3'd5, 32'd6, 3'b000,
			32'd0));
		queue_beat(make_beat(REQ_EDGE, PHASE_C, EDGE_FALL, 3'd5, 3'd0, 32'd7, 3'b000, 32'd3));
		queue_beat(make_beat(REQ_SECTION_END, PHASE_C, EDGE_FALL, 3'd5, SYNC_SECTION_ALT, 32'd8,
			3'b111, 32'd3));
		queue_beat(make_beat(REQ_SECTION_END, PHASE_A, EDGE_RISE, 3'd4, 3'd4, 32'd9, 3'b111,
			32'd3));
		settle();
		// disabling clears the enables even after re-enabling
		set_measure(1'b0);
		set_measure(1'b1);
		queue_beat(make_beat(REQ_EDGE, PHASE_A, EDGE_RISE, 3'd4, 3'd0, 32'd11, 3'b001, 32'd3));
		queue_beat(make_beat(REQ_SECTION_END, PHASE_A, EDGE_RISE, 3'd4, 3'd0, 32'd12, 3'b001,
			32'd3));

		// random phases, measurement switched between them
		for (int p = 0; p < 7; p++) begin
			settle();
			set_measure(plan[p]);
			quota = plan[p] ? 240 : 60;
			start = pushed;
			while (pushed - start < quota) begin
				if ($urandom_range(0, 99) < 85)
					queue_rotation($urandom_range(3, 12));
				else
					repeat ($urandom_range(1, 4)) queue_noise();
			end
		end

		settle();
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
